[rtl/core/tlg_pkg.sv]
// Shared types, constants and helpers for the toroidal life grid engine.
`timescale 1ns / 1ps
`default_nettype none

package tlg_pkg;

  // Default grid bounds
  localparam int MAX_ROWS_DEFAULT = 64;
  localparam int MAX_COLS_DEFAULT = 64;

  // Reset sizes of the torus
  localparam int ROWS_RESET = 10;
  localparam int COLS_RESET = 10;

  // Item field widths
  localparam int MODE_W = 2;
  localparam int ROW_W  = 6;
  localparam int COL_W  = 6;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

  // B3/S23 rule counts
  localparam int BIRTH_COUNT = 3;
  localparam int KEEP_COUNT  = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_GEN   = 2'd2
  } mode_t;

  // Zero is taken as one, anything above the bound saturates.
  function automatic int clamp_size(logic [CFG_DW-1:0] v, int maxv);
    int r;
    r = int'(v);
    if (r == 0) begin
      return 1;
    end
    if (r > maxv) begin
      return maxv;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/toroidal_life_grid_engine_top.sv]
// Top level of the toroidal life grid engine: sequencer, window registers, ports.
`timescale 1ns / 1ps
`default_nettype none

// Channel | Handshake           | Payload                      | Notes
// in      | in_valid/in_ready   | mode, row, col, cell_value   | one beat per item
// out     | out_valid/out_ready | cell_state                   | reads only
// cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data          | 0 rows, 1 cols
//
// Cell write or read: accept, then row memory data back in ST_OP; a read
//   waits further only while the output register is still full.
// Generation: preload reads of the row window (ST_P0 to ST_P3), then one
//   row per cycle through the shared row unit (ST_ROW) up to the last row.
//   The single row memory port pair allows one row read, one row write a cycle.
// Reset clears the grid at once through per-row valid bits; a size write does too.
// in_ready and cfg_ready are high only while the sequencer is idle.

module toroidal_life_grid_engine_top #(
  parameter int MAX_ROWS = tlg_pkg::MAX_ROWS_DEFAULT,
  parameter int MAX_COLS = tlg_pkg::MAX_COLS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input items
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [tlg_pkg::MODE_W-1:0]    mode,
  input  wire logic [tlg_pkg::ROW_W-1:0]     row,
  input  wire logic [tlg_pkg::COL_W-1:0]     col,
  input  wire logic                          cell_value,
  // results
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               cell_state,
  // configuration
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tlg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tlg_pkg::CFG_DW-1:0]    cfg_data
);

  import tlg_pkg::*;

  localparam int RAW = $clog2(MAX_ROWS);
  localparam int CAW = $clog2(MAX_COLS);
  localparam int RSW = $clog2(MAX_ROWS + 1);
  localparam int CSW = $clog2(MAX_COLS + 1);
  localparam int ROWS_INIT = (ROWS_RESET > MAX_ROWS) ? MAX_ROWS : ROWS_RESET;
  localparam int COLS_INIT = (COLS_RESET > MAX_COLS) ? MAX_COLS : COLS_RESET;

  typedef enum logic [2:0] {
    ST_IDLE,  // waiting for an item
    ST_OP,    // cell write or read, row data back
    ST_P0,    // read old last row
    ST_P1,    // read old row 0, capture window top
    ST_P2,    // read old row 1, capture window middle
    ST_P3,    // read old row 2, capture window bottom
    ST_ROW    // rewrite one row per cycle
  } state_t;

  state_t             state;
  logic [RSW-1:0]     rows_in_use;
  logic [CSW-1:0]     cols_in_use;
  logic [MODE_W-1:0]  mode_q;
  logic [ROW_W-1:0]   row_q;
  logic [COL_W-1:0]   col_q;
  logic               val_q;
  logic [RAW-1:0]     gen_row;

  // Sliding window of old rows, plus old row 0 kept for the wrap at the bottom
  logic [MAX_COLS-1:0] win_prev, win_cur, win_next, old_row0;

  logic                in_fire, cfg_fire, cfg_size_wr;
  logic                hit, last_row, wrap_fetch;
  logic [CAW-1:0]      col_idx;
  logic [RAW-1:0]      rd_addr, wr_addr;
  logic                wr_en;
  logic [MAX_COLS-1:0] wr_data, rd_row, gen_out, mod_row;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_size_wr = cfg_fire && ((cfg_index == CFG_ROWS) || (cfg_index == CFG_COLS));

  assign hit = (32'(row_q) < 32'(rows_in_use)) && (32'(col_q) < 32'(cols_in_use));
  assign col_idx = CAW'(col_q);
  assign last_row = (32'(gen_row) + 32'd1) == 32'(rows_in_use);
  // Row r+2 past the end of the torus is old row 0, already rewritten in memory
  assign wrap_fetch = (32'(gen_row) + 32'd2) >= 32'(rows_in_use);

  always_comb begin
    mod_row = rd_row;
    mod_row[col_idx] = val_q;
  end

  // Read address schedule: memory data comes back in the cycle after the address
  always_comb begin
    unique case (state)
      ST_IDLE: rd_addr = RAW'(row);
      ST_OP:   rd_addr = RAW'(row_q);
      ST_P0:   rd_addr = RAW'(rows_in_use - 1'b1);
      ST_P1:   rd_addr = '0;
      ST_P2:   rd_addr = (32'(rows_in_use) == 32'd1) ? RAW'(0) : RAW'(1);
      ST_P3:   rd_addr = RAW'(2);
      ST_ROW:  rd_addr = RAW'(32'(gen_row) + 32'd3);
      default: rd_addr = '0;
    endcase
  end

  assign wr_en   = (state == ST_ROW) ||
                   ((state == ST_OP) && (mode_q == MODE_WRITE) && hit);
  assign wr_addr = (state == ST_ROW) ? gen_row : RAW'(row_q);
  assign wr_data = (state == ST_ROW) ? gen_out : mod_row;

  tlg_row_mem #(
    .DEPTH (MAX_ROWS),
    .WIDTH (MAX_COLS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .clear   (cfg_size_wr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_row)
  );

  tlg_row_unit #(
    .MAX_COLS (MAX_COLS)
  ) u_row (
    .win_prev    (win_prev),
    .win_cur     (win_cur),
    .win_next    (win_next),
    .cols_in_use (cols_in_use),
    .row_out     (gen_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      rows_in_use <= RSW'(ROWS_INIT);
      cols_in_use <= CSW'(COLS_INIT);
      gen_row     <= '0;
    end else begin
      // a read finishing this cycle reloads the output register itself
      if (out_valid && out_ready && !((state == ST_OP) && (mode_q == MODE_READ))) begin
        out_valid <= 1'b0;
      end

      if (cfg_fire) begin
        unique case (cfg_index)
          CFG_ROWS: rows_in_use <= RSW'(clamp_size(cfg_data, MAX_ROWS));
          CFG_COLS: cols_in_use <= CSW'(clamp_size(cfg_data, MAX_COLS));
          default:  ;  // unknown register: no effect
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            mode_q <= mode;
            row_q  <= row;
            col_q  <= col;
            val_q  <= cell_value;
            priority if (mode == MODE_GEN) begin
              state <= ST_P0;
            end else if ((mode == MODE_WRITE) || (mode == MODE_READ)) begin
              state <= ST_OP;
            end else begin
              state <= ST_IDLE;  // unused mode code: dropped
            end
          end
        end
        ST_OP: begin
          if (mode_q == MODE_READ) begin
            // hold until the output register frees up
            if (!out_valid || out_ready) begin
              out_valid  <= 1'b1;
              cell_state <= hit ? rd_row[col_idx] : 1'b0;
              state      <= ST_IDLE;
            end
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_P0: begin
          state <= ST_P1;
        end
        ST_P1: begin
          win_prev <= rd_row;
          state    <= ST_P2;
        end
        ST_P2: begin
          win_cur  <= rd_row;
          old_row0 <= rd_row;
          state    <= ST_P3;
        end
        ST_P3: begin
          win_next <= rd_row;
          gen_row  <= '0;
          state    <= ST_ROW;
        end
        ST_ROW: begin
          win_prev <= win_cur;
          win_cur  <= win_next;
          win_next <= wrap_fetch ? old_row0 : rd_row;
          gen_row  <= gen_row + 1'b1;
          if (last_row) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The last row of a generation hands control straight back
  a_gen_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROW) && last_row |=> in_ready)
    else $error("generation did not return to idle after last row");

  // A result only ever comes from a read that finished its row fetch
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_OP) && ($past(mode_q) == MODE_READ))
    else $error("result raised outside a read");

  // Size registers stay within their clamped range
  a_sizes: assert property (@(posedge clk) disable iff (rst)
    (rows_in_use != '0) && (32'(rows_in_use) <= MAX_ROWS) &&
    (cols_in_use != '0) && (32'(cols_in_use) <= MAX_COLS))
    else $error("grid size register out of range");

  // Memory rewrites during a generation only while the window is loaded
  a_gen_write: assert property (@(posedge clk) disable iff (rst)
    wr_en && (state != ST_OP) |-> ($past(state) == ST_P3) || ($past(state) == ST_ROW))
    else $error("row write outside the generation walk");

endmodule

`default_nettype wire

[rtl/core/tlg_row_mem.sv]
// Grid row memory with per-row valid bits; an invalid row reads as all dead.
`timescale 1ns / 1ps
`default_nettype none

module tlg_row_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     clear,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] row_valid;
  logic [WIDTH-1:0] rd_q;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row_valid <= '0;
      rd_vld    <= 1'b0;
    end else begin
      rd_vld <= row_valid[rd_addr];
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

`default_nettype wire

[rtl/core/tlg_row_unit.sv]
// Next-generation row from a window of three old rows, columns wrapped.
`timescale 1ns / 1ps
`default_nettype none

module tlg_row_unit #(
  parameter int MAX_COLS = 64
) (
  input  wire logic [MAX_COLS-1:0]         win_prev,
  input  wire logic [MAX_COLS-1:0]         win_cur,
  input  wire logic [MAX_COLS-1:0]         win_next,
  input  wire logic [$clog2(MAX_COLS+1)-1:0] cols_in_use,
  output logic      [MAX_COLS-1:0]         row_out
);

  import tlg_pkg::*;

  localparam int CAW = $clog2(MAX_COLS);

  logic [CAW-1:0] col_last;
  logic           wrap_p, wrap_c, wrap_n;

  assign col_last = CAW'(cols_in_use - 1'b1);
  assign wrap_p   = win_prev[col_last];
  assign wrap_c   = win_cur[col_last];
  assign wrap_n   = win_next[col_last];

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_cell
    logic       lp, lc, ln, rp, rc, rn;
    logic [3:0] n;
    logic       in_use;

    if (c == 0) begin : g_left_wrap
      assign lp = wrap_p;
      assign lc = wrap_c;
      assign ln = wrap_n;
    end else begin : g_left
      assign lp = win_prev[c-1];
      assign lc = win_cur[c-1];
      assign ln = win_next[c-1];
    end

    if (c == MAX_COLS - 1) begin : g_right_wrap
      assign rp = win_prev[0];
      assign rc = win_cur[0];
      assign rn = win_next[0];
    end else begin : g_right
      // Last column in use wraps to column zero
      assign rp = (col_last == CAW'(c)) ? win_prev[0] : win_prev[c+1];
      assign rc = (col_last == CAW'(c)) ? win_cur[0]  : win_cur[c+1];
      assign rn = (col_last == CAW'(c)) ? win_next[0] : win_next[c+1];
    end

    assign in_use = 32'(cols_in_use) > c;
    assign n = 4'(lp) + 4'(win_prev[c]) + 4'(rp) + 4'(lc) + 4'(rc)
             + 4'(ln) + 4'(win_next[c]) + 4'(rn);

    always_comb begin
      if (!in_use) begin
        row_out[c] = 1'b0;
      end else if (n == 4'(BIRTH_COUNT)) begin
        row_out[c] = 1'b1;
      end else if (n == 4'(KEEP_COUNT)) begin
        row_out[c] = win_cur[c];
      end else begin
        row_out[c] = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[verif/tlg_grid_checker.sv]
// Scoreboard for the toroidal life grid engine: mirrors the grid and checks every read beat.
`timescale 1ns / 1ps

module tlg_grid_checker #(
  parameter int MAX_ROWS = tlg_pkg::MAX_ROWS_DEFAULT,
  parameter int MAX_COLS = tlg_pkg::MAX_COLS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [tlg_pkg::MODE_W-1:0]    mode,
  input  logic [tlg_pkg::ROW_W-1:0]     row,
  input  logic [tlg_pkg::COL_W-1:0]     col,
  input  logic                          cell_value,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          cell_state,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [tlg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tlg_pkg::CFG_DW-1:0]    cfg_data,
  output int                            fail_count,
  output int                            pending_count,
  output int                            reads_checked
);

  import tlg_pkg::*;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             state;
  } cell_read_t;

  logic [MAX_COLS-1:0] life_grid [MAX_ROWS];
  int                  rows_live;
  int                  cols_live;
  cell_read_t          expected_reads [$];

  function automatic void clear_grid();
    foreach (life_grid[i]) life_grid[i] = '0;
  endfunction

  function automatic void log_failure(string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] checker: %s", $time, msg);
    end
  endfunction

  // B3/S23 on the torus; every neighbor is taken from the previous generation,
  // wrapped indexes counted with their repeats on tiny grids.
  task automatic advance_generation();
    logic [MAX_COLS-1:0] prev [MAX_ROWS];
    int                  n;
    prev = life_grid;
    for (int r = 0; r < rows_live; r++) begin
      for (int c = 0; c < cols_live; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) begin
              n += int'(prev[(r + dr + rows_live) % rows_live][(c + dc + cols_live) % cols_live]);
            end
          end
        end
        if (n == BIRTH_COUNT) begin
          life_grid[r][c] = 1'b1;
        end else if (n != KEEP_COUNT) begin
          life_grid[r][c] = 1'b0;
        end
      end
    end
  endtask

  initial begin
    fail_count    = 0;
    pending_count = 0;
    reads_checked = 0;
    rows_live     = ROWS_RESET;
    cols_live     = COLS_RESET;
    clear_grid();
  end

  always @(posedge clk) begin
    cell_read_t want;
    int         sz;
    if (rst) begin
      clear_grid();
      rows_live = ROWS_RESET;
      cols_live = COLS_RESET;
      expected_reads.delete();
    end else begin
      if (out_valid && out_ready) begin
        reads_checked++;
        if (expected_reads.size() == 0) begin
          log_failure($sformatf("read beat with no read pending, cell_state %0b", cell_state));
        end else begin
          want = expected_reads.pop_front();
          if (cell_state !== want.state) begin
            log_failure($sformatf("cell (%0d,%0d): expected %0b, got %0b",
                                  want.row, want.col, want.state, cell_state));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        sz = int'(cfg_data);
        if (sz == 0) sz = 1;
        case (cfg_index)
          CFG_ROWS: begin
            rows_live = (sz > MAX_ROWS) ? MAX_ROWS : sz;
            clear_grid();
          end
          CFG_COLS: begin
            cols_live = (sz > MAX_COLS) ? MAX_COLS : sz;
            clear_grid();
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (mode)
          MODE_WRITE: begin
            if (int'(row) < rows_live && int'(col) < cols_live) begin
              life_grid[row][col] = cell_value;
            end
          end
          MODE_READ: begin
            want.row   = row;
            want.col   = col;
            want.state = (int'(row) < rows_live && int'(col) < cols_live) ?
                         life_grid[row][col] : 1'b0;
            expected_reads.push_back(want);
          end
          MODE_GEN: advance_generation();
          default: ;
        endcase
      end
    end
    pending_count = expected_reads.size();
  end

endmodule

[verif/tb_toroidal_life_grid_engine_top.sv]
// Testbench top for the toroidal life grid engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_toroidal_life_grid_engine_top;
  import tlg_pkg::*;

  // Mode 3 and config indexes 2/3 decode to nothing in the block.
  localparam logic [MODE_W-1:0]    MODE_SPARE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // Room for a full-size generation to run after its beat, with padding.
  localparam int SETTLE_CYCLES = MAX_ROWS_DEFAULT + 16;
  // Long receiver hold-off: block fills its output register and blocks input.
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 40;
  // Cycles without any beat on any channel before the run is declared hung.
  localparam int QUIET_LIMIT   = 4000;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [MODE_W-1:0]    mode;
  logic [ROW_W-1:0]     row;
  logic [COL_W-1:0]     col;
  logic                 cell_value;
  logic                 out_valid;
  logic                 out_ready;
  logic                 cell_state;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DW-1:0]    cfg_data;

  int fail_count;
  int pending_count;
  int reads_checked;

  // Torus size in effect, so stimulus can aim writes and reads inside it.
  int rows_set;
  int cols_set;
  int items_sent;
  int gens_sent;
  int cfg_writes;
  // When set, neither side idles: back-to-back beats.
  bit steady;

  toroidal_life_grid_engine_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .row        (row),
    .col        (col),
    .cell_value (cell_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cell_state (cell_state),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  tlg_grid_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .row           (row),
    .col           (col),
    .cell_value    (cell_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cell_state    (cell_state),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .reads_checked (reads_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idle length from three bands: mostly the shortest, sometimes medium, rarely long.
  function automatic int idle_span();
    int p;
    p = int'($urandom_range(0, 99));
    if (p < 70) return int'($urandom_range(1, 2));
    if (p < 95) return int'($urandom_range(3, 8));
    return int'($urandom_range(20, 60));
  endfunction

  // One item beat. Called at a falling edge, returns at the falling edge after
  // acceptance without touching in_valid, so the next beat can follow directly.
  task automatic send_item(input logic [MODE_W-1:0] m, input int r, input int c,
                           input bit v);
    int gap;
    gap = (steady || $urandom_range(0, 99) < 55) ? 0 : idle_span();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    row        <= ROW_W'(r);
    col        <= COL_W'(c);
    cell_value <= v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (m != MODE_SPARE) items_sent++;
    if (m == MODE_GEN) gens_sent++;
  endtask

  // Drop valid, let every read drain, then give a running generation time to end.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DW'(v);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
    @(negedge clk);
  endtask

  // Mostly well-formed episodes: seed a small wrapped window, run a few
  // generations, read back inside the window. The rest is loose noise with
  // any mode and any coordinate, out-of-range ones included.
  task automatic run_random(input int target);
    int sent;
    int r0;
    int c0;
    int k;
    logic [MODE_W-1:0] m;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(0, 9) < 7) begin
        r0 = int'($urandom_range(0, rows_set - 1));
        c0 = int'($urandom_range(0, cols_set - 1));
        k  = int'($urandom_range(3, 14));
        repeat (k) begin
          send_item(MODE_WRITE, (r0 + int'($urandom_range(0, 5))) % rows_set,
                    (c0 + int'($urandom_range(0, 5))) % cols_set, $urandom_range(0, 9) < 6);
          sent++;
        end
        k = int'($urandom_range(1, 4));
        repeat (k) begin
          send_item(MODE_GEN, int'($urandom_range(0, 63)), int'($urandom_range(0, 63)),
                    $urandom_range(0, 1) == 1);
          sent++;
        end
        k = int'($urandom_range(2, 8));
        repeat (k) begin
          send_item(MODE_READ, (r0 + int'($urandom_range(0, 5))) % rows_set,
                    (c0 + int'($urandom_range(0, 5))) % cols_set, $urandom_range(0, 1) == 1);
          sent++;
        end
      end else begin
        m = MODE_W'($urandom_range(0, 3));
        send_item(m, int'($urandom_range(0, 63)), int'($urandom_range(0, 63)),
                  $urandom_range(0, 1) == 1);
        if (m != MODE_SPARE) sent++;
      end
    end
  endtask

  // New torus size: both size registers written while idle, grid cleared by each.
  task automatic run_phase(input int rows_val, input int cols_val, input int items);
    settle();
    cfg_write(CFG_ROWS, rows_val);
    cfg_write(CFG_COLS, cols_val);
    rows_set = (rows_val == 0) ? 1 : ((rows_val > MAX_ROWS_DEFAULT) ? MAX_ROWS_DEFAULT : rows_val);
    cols_set = (cols_val == 0) ? 1 : ((cols_val > MAX_COLS_DEFAULT) ? MAX_COLS_DEFAULT : cols_val);
    run_random(items);
  endtask

  // Result side: random stalls, one long hold-off once reads are flowing.
  initial begin : result_sink
    int stall;
    bit held;
    stall     = 0;
    held      = 1'b0;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && reads_checked >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else if (!steady && $urandom_range(0, 99) < 20) begin
        out_ready <= 1'b0;
        stall = idle_span() - 1;
      end else begin
        out_ready <= 1'b1;
      end
      @(negedge clk);
    end
  end

  // Hang detector: any beat on any channel restarts the count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no beat for %0d cycles, %0d reads outstanding", quiet, pending_count);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    rst        = 1'b1;
    in_valid   = 1'b0;
    mode       = MODE_WRITE;
    row        = '0;
    col        = '0;
    cell_value = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_ROWS;
    cfg_data   = '0;
    steady     = 1'b0;
    rows_set   = ROWS_RESET;
    cols_set   = COLS_RESET;
    items_sent = 0;
    gens_sent  = 0;
    cfg_writes = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, on the 10x10 reset torus.
    send_item(MODE_READ, 0, 0, 1'b0);        // grid cleared by reset
    send_item(MODE_WRITE, 0, 0, 1'b1);
    send_item(MODE_READ, 0, 0, 1'b0);
    send_item(MODE_WRITE, 9, 9, 1'b1);       // last in-range cell
    send_item(MODE_READ, 9, 9, 1'b1);
    send_item(MODE_WRITE, 63, 63, 1'b1);     // outside: dropped
    send_item(MODE_READ, 63, 63, 1'b0);      // outside: reads dead
    send_item(MODE_WRITE, 10, 0, 1'b1);      // first row past the edge
    send_item(MODE_READ, 10, 0, 1'b0);
    send_item(MODE_READ, 0, 10, 1'b1);
    send_item(MODE_SPARE, 63, 63, 1'b1);     // no-op mode, no beat back
    // Vertical blinker straddling the row seam (rows 9, 0, 1 at column 0).
    send_item(MODE_WRITE, 9, 0, 1'b1);
    send_item(MODE_WRITE, 1, 0, 1'b1);
    send_item(MODE_GEN, 0, 0, 1'b0);
    send_item(MODE_READ, 0, 9, 1'b0);
    send_item(MODE_READ, 0, 1, 1'b0);
    send_item(MODE_READ, 9, 0, 1'b0);
    send_item(MODE_GEN, 63, 63, 1'b1);
    send_item(MODE_READ, 9, 0, 1'b1);
    send_item(MODE_READ, 0, 0, 1'b1);

    run_random(150);

    // Size sweep: zero reads as one, above the bound saturates, tiny tori
    // count wrapped neighbors with repeats.
    run_phase(0, 0, 120);
    run_phase(2, 1, 140);
    run_phase(127, 64, 160);
    steady = 1'b1;
    run_phase(3, 2, 140);
    steady = 1'b0;
    run_phase(1, 65, 150);
    run_phase(64, 3, 150);
    run_phase(int'($urandom_range(1, 16)), int'($urandom_range(1, 16)), 150);
    run_phase(5, 7, 150);
    // Unused register indexes must leave the grid and sizes alone.
    settle();
    cfg_write(CFG_SPARE_A, 127);
    cfg_write(CFG_SPARE_B, 0);
    steady = 1'b1;
    run_random(50);
    steady = 1'b0;
    run_random(50);

    // Drain: every read back, then room for a trailing generation or stray beat.
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Covered %0d items with %0d generations and %0d checked reads,",
             items_sent, gens_sent, reads_checked);
    $display("across %0d config writes, torus sizes from 1x1 up to 64x64.", cfg_writes);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[toroidal_life_grid_engine_top.f]
rtl/core/tlg_pkg.sv
rtl/core/tlg_row_mem.sv
rtl/core/tlg_row_unit.sv
rtl/core/toroidal_life_grid_engine_top.sv
verif/tlg_grid_checker.sv
verif/tb_toroidal_life_grid_engine_top.sv
